>>> rtl/core/psc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg
// Types and constants shared by the power sequence controller modules.
// ----------------------------------------------------------------------------
package psc_pkg;

    typedef struct packed {
        logic [9:0] elapsed_ms;
        logic       button_down;
        logic [9:0] dc_sample;
        logic [9:0] ac_sample;
        logic [1:0] line_code;
    } psc_in_t;

    typedef struct packed {
        logic [3:0] ctrl_state_out;
        logic       relay_ac_a_on;
        logic       relay_ac_b_on;
        logic       relay_dc_on;
        logic       led_on;
        logic [2:0] buzz_pattern;
        logic [1:0] host_code;
        logic [3:0] fail_count_out;
    } psc_out_t;

    typedef struct packed {
        logic [15:0] init_wait_sec;
        logic [15:0] ac_timeout_sec;
        logic [15:0] camera_boot_sec;
        logic [15:0] pc_boot_sec;
        logic [15:0] dc_gone_sec;
        logic [15:0] shutdown_ack_sec;
        logic [15:0] power_off_wait_sec;
        logic [7:0]  ac_detect_min;
    } psc_cfg_t;

    typedef struct packed {
        logic [3:0]  ctrl_state;
        logic [10:0] ms_accum;
        logic [15:0] sec_count;
        logic [3:0]  fail_count;
        logic [7:0]  ac_hits;
        logic        force_flag;
        logic [1:0]  report_code;
        logic [2:0]  relay_bits;
        logic        led_bit;
        logic [11:0] long_press_ms;
        logic        long_latched;
        logic [11:0] short_press_ms;
        logic        short_armed;
    } psc_state_t;

    localparam logic [2:0] CFG_INIT_WAIT      = 3'd0;
    localparam logic [2:0] CFG_AC_TIMEOUT     = 3'd1;
    localparam logic [2:0] CFG_CAMERA_BOOT    = 3'd2;
    localparam logic [2:0] CFG_PC_BOOT        = 3'd3;
    localparam logic [2:0] CFG_DC_GONE        = 3'd4;
    localparam logic [2:0] CFG_SHUTDOWN_ACK   = 3'd5;
    localparam logic [2:0] CFG_POWER_OFF_WAIT = 3'd6;
    localparam logic [2:0] CFG_AC_DETECT_MIN  = 3'd7;

    localparam psc_cfg_t CFG_RESET = '{
        init_wait_sec:      16'd5,
        ac_timeout_sec:     16'd60,
        camera_boot_sec:    16'd60,
        pc_boot_sec:        16'd30,
        dc_gone_sec:        16'd30,
        shutdown_ack_sec:   16'd300,
        power_off_wait_sec: 16'd60,
        ac_detect_min:      8'd10
    };

    localparam logic [3:0] ST_INIT       = 4'd0;
    localparam logic [3:0] ST_RELAY_INIT = 4'd1;
    localparam logic [3:0] ST_AC_WAIT    = 4'd2;
    localparam logic [3:0] ST_AC_CHECK   = 4'd3;
    localparam logic [3:0] ST_CAM_BOOT   = 4'd4;
    localparam logic [3:0] ST_PC_RELAY   = 4'd5;
    localparam logic [3:0] ST_PC_BOOT    = 4'd6;
    localparam logic [3:0] ST_IDLE       = 4'd7;
    localparam logic [3:0] ST_SHUTDOWN   = 4'd8;
    localparam logic [3:0] ST_POWER_OFF  = 4'd9;
    localparam logic [3:0] ST_DISCHARGE  = 4'd10;
    localparam logic [3:0] ST_ERROR      = 4'd11;

    localparam logic [2:0] RELAY_AC_A = 3'b001;
    localparam logic [2:0] RELAY_AC_B = 3'b010;
    localparam logic [2:0] RELAY_DC   = 3'b100;

    localparam logic [2:0] BUZZ_NONE        = 3'd0;
    localparam logic [2:0] BUZZ_BEEP        = 3'd1;
    localparam logic [2:0] BUZZ_FAST_CHIRP  = 3'd2;
    localparam logic [2:0] BUZZ_SLOW_CHIRP  = 3'd3;
    localparam logic [2:0] BUZZ_TRIPLE_SLOW = 3'd4;

    localparam logic [1:0] HOST_ITS0 = 2'd0;
    localparam logic [1:0] HOST_ITS1 = 2'd1;
    localparam logic [1:0] HOST_ITS2 = 2'd2;
    localparam logic [1:0] HOST_ITS3 = 2'd3;

    localparam logic [1:0] LINE_NONE = 2'd0;

    localparam logic [9:0]  ON_LEVEL   = 10'd300;
    localparam logic [11:0] LONG_MS    = 12'd2000;
    localparam logic [11:0] SHORT_MS   = 12'd100;
    localparam logic [10:0] INIT_MS    = 11'd200;
    localparam logic [10:0] SEC_MS     = 11'd1000;
    localparam logic [3:0]  FAIL_LIMIT = 4'd5;

endpackage

`default_nettype wire

>>> rtl/core/psc_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_step
// Next-state and result logic of the sequencer for one control period.
// ----------------------------------------------------------------------------
module psc_step (
    input  psc_pkg::psc_in_t    item,
    input  psc_pkg::psc_cfg_t   cfg,
    input  psc_pkg::psc_state_t cur,
    output psc_pkg::psc_state_t nxt,
    output psc_pkg::psc_out_t   result
);
    import psc_pkg::*;

    logic        dc_on;
    logic        ac_on;
    logic        line;
    logic [11:0] ms_sum;
    logic [12:0] short_sum;
    logic [12:0] long_sum;
    logic [10:0] tick_ms;
    logic [4:0]  fail_sum;
    logic [2:0]  buzz;
    logic        long_fire;
    logic        short_fire;
    psc_state_t  s;

    assign dc_on = item.dc_sample > ON_LEVEL;
    assign ac_on = item.ac_sample > ON_LEVEL;
    assign line  = item.line_code != LINE_NONE;

    always_comb
    begin
        s          = cur;
        buzz       = BUZZ_NONE;
        long_fire  = 1'b0;
        short_fire = 1'b0;
        fail_sum   = '0;

        ms_sum    = {1'b0, cur.ms_accum} + {2'b00, item.elapsed_ms};
        s.ms_accum = (ms_sum > 12'd2047) ? 11'd2047 : ms_sum[10:0];
        short_sum = {1'b0, cur.short_press_ms} + {3'b000, item.elapsed_ms};
        s.short_press_ms = (short_sum > 13'd4095) ? 12'd4095 : short_sum[11:0];
        tick_ms   = s.ms_accum;
        if (tick_ms > SEC_MS)
        begin
            s.ms_accum = '0;
            if (s.sec_count != 16'hFFFF)
                s.sec_count = s.sec_count + 16'd1;
        end

        long_sum = {1'b0, cur.long_press_ms} + {3'b000, item.elapsed_ms};
        if (item.button_down)
        begin
            s.long_press_ms = (long_sum > 13'd4095) ? 12'd4095 : long_sum[11:0];
            if (s.long_press_ms > LONG_MS && !s.long_latched)
            begin
                s.long_latched = 1'b1;
                buzz           = BUZZ_BEEP;
                long_fire      = 1'b1;
            end
        end
        else
        begin
            s.long_latched  = 1'b0;
            s.long_press_ms = '0;
        end

        if (long_fire)
        begin
            if (s.ctrl_state < ST_IDLE || s.ctrl_state == ST_ERROR)
            begin
                s.ctrl_state = ST_IDLE;
                s.relay_bits = RELAY_AC_A | RELAY_AC_B | RELAY_DC;
                buzz         = BUZZ_BEEP;
                s.force_flag = 1'b1;
            end
            else
            begin
                s.ctrl_state = ST_DISCHARGE;
                s.fail_count = '0;
                s.led_bit    = 1'b0;
                s.relay_bits = RELAY_DC;
                buzz         = BUZZ_SLOW_CHIRP;
                s.force_flag = 1'b0;
            end
            s.ms_accum  = '0;
            s.sec_count = '0;
        end

        unique case (s.ctrl_state)
            ST_ERROR:
            begin
                if (item.button_down)
                    s.short_armed = 1'b1;
                else if (s.short_armed)
                begin
                    s.short_armed = 1'b0;
                    short_fire = s.short_press_ms > SHORT_MS && s.short_press_ms < LONG_MS;
                end
                else
                    s.short_press_ms = '0;
                if (short_fire)
                begin
                    s.relay_bits  = RELAY_DC;
                    s.report_code = HOST_ITS0;
                    s.fail_count  = '0;
                    s.ms_accum    = '0;
                    s.sec_count   = '0;
                    s.ctrl_state  = ST_INIT;
                end
            end
            ST_INIT:
            begin
                s.led_bit     = 1'b1;
                s.relay_bits  = RELAY_DC;
                s.report_code = HOST_ITS0;
                if (dc_on)
                begin
                    if (s.fail_count < FAIL_LIMIT)
                    begin
                        buzz         = BUZZ_BEEP;
                        s.ctrl_state = ST_RELAY_INIT;
                        s.ms_accum   = '0;
                        s.sec_count  = '0;
                    end
                    else
                    begin
                        buzz         = BUZZ_TRIPLE_SLOW;
                        s.ctrl_state = ST_ERROR;
                    end
                end
            end
            ST_RELAY_INIT:
            begin
                if (tick_ms > INIT_MS)
                begin
                    s.ctrl_state = ST_AC_WAIT;
                    s.relay_bits = s.relay_bits | RELAY_DC | RELAY_AC_A;
                    s.led_bit    = 1'b0;
                    s.ms_accum   = '0;
                    s.sec_count  = '0;
                end
            end
            ST_AC_WAIT:
            begin
                if (s.sec_count > cfg.init_wait_sec)
                begin
                    s.ctrl_state = ST_AC_CHECK;
                    s.ms_accum   = '0;
                    s.sec_count  = '0;
                end
            end
            ST_AC_CHECK:
            begin
                if (ac_on && s.ac_hits != 8'hFF)
                    s.ac_hits = s.ac_hits + 8'd1;
                if (s.ac_hits > cfg.ac_detect_min)
                begin
                    s.ctrl_state = ST_CAM_BOOT;
                    s.ac_hits    = '0;
                    s.ms_accum   = '0;
                    s.sec_count  = '0;
                end
                if (s.sec_count > cfg.ac_timeout_sec)
                begin
                    s.relay_bits = s.relay_bits | RELAY_DC;
                    s.ctrl_state = ST_DISCHARGE;
                    fail_sum     = {1'b0, s.fail_count} + 5'd5;
                    s.fail_count = (fail_sum > 5'd15) ? 4'd15 : fail_sum[3:0];
                end
            end
            ST_CAM_BOOT:
            begin
                if (s.sec_count > cfg.camera_boot_sec)
                    s.ctrl_state = ST_PC_RELAY;
            end
            ST_PC_RELAY:
            begin
                s.relay_bits = s.relay_bits | RELAY_AC_B;
                s.ms_accum   = '0;
                s.sec_count  = '0;
                s.ctrl_state = ST_PC_BOOT;
            end
            ST_PC_BOOT:
            begin
                if (line)
                begin
                    s.ctrl_state = ST_IDLE;
                    buzz         = BUZZ_FAST_CHIRP;
                    s.led_bit    = 1'b1;
                end
                if (s.sec_count > cfg.pc_boot_sec)
                    s.ctrl_state = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (dc_on || s.force_flag)
                begin
                    s.ms_accum    = '0;
                    s.sec_count   = '0;
                    s.report_code = HOST_ITS0;
                end
                if (s.sec_count > cfg.dc_gone_sec || line)
                begin
                    s.ctrl_state  = ST_SHUTDOWN;
                    s.report_code = HOST_ITS1;
                    s.ms_accum    = '0;
                    s.sec_count   = '0;
                end
            end
            ST_SHUTDOWN:
            begin
                if (line)
                begin
                    s.ctrl_state  = ST_POWER_OFF;
                    buzz          = BUZZ_FAST_CHIRP;
                    s.led_bit     = 1'b0;
                    s.ms_accum    = '0;
                    s.sec_count   = '0;
                    s.report_code = HOST_ITS2;
                end
                if (s.sec_count > cfg.shutdown_ack_sec)
                begin
                    s.ctrl_state  = ST_POWER_OFF;
                    fail_sum      = {1'b0, s.fail_count} + 5'd1;
                    s.fail_count  = (fail_sum > 5'd15) ? 4'd15 : fail_sum[3:0];
                    s.report_code = HOST_ITS2;
                end
            end
            ST_POWER_OFF:
            begin
                if (s.sec_count > cfg.power_off_wait_sec)
                begin
                    s.ctrl_state  = ST_DISCHARGE;
                    s.relay_bits  = RELAY_DC;
                    s.ms_accum    = '0;
                    s.sec_count   = '0;
                    s.report_code = HOST_ITS3;
                    s.force_flag  = 1'b0;
                end
            end
            ST_DISCHARGE:
            begin
                if (s.sec_count > cfg.dc_gone_sec)
                    s.ctrl_state = ST_INIT;
            end
            default:
            begin
            end
        endcase
    end

    assign nxt = s;

    assign result.ctrl_state_out = s.ctrl_state;
    assign result.relay_ac_a_on  = |(s.relay_bits & RELAY_AC_A);
    assign result.relay_ac_b_on  = |(s.relay_bits & RELAY_AC_B);
    assign result.relay_dc_on    = |(s.relay_bits & RELAY_DC);
    assign result.led_on         = s.led_bit;
    assign result.buzz_pattern   = buzz;
    assign result.host_code      = s.report_code;
    assign result.fail_count_out = s.fail_count;

endmodule

`default_nettype wire

>>> rtl/core/power_sequence_controller_top.sv
`default_nettype none
// An item passes through the input register and then the result register before its result is valid.
// Throughput: one item per cycle while the result side does not stall.
// The state update runs in the cycle an item moves from the input register to the result.
// Reset: asynchronous, active low; sequencer state, counters and flags clear, registers
// return to their default values, both pipeline stages empty.
// ----------------------------------------------------------------------------
// power_sequence_controller_top
// Relay power sequencer with button press detection and host handshake.
// ----------------------------------------------------------------------------
module power_sequence_controller_top (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic in_valid,
    output                     logic in_stall,
    input  psc_pkg::psc_in_t   in_item,
    output                     logic out_valid,
    input  wire                logic out_stall,
    output psc_pkg::psc_out_t  out_item,
    input  wire                logic cfg_valid,
    output                     logic cfg_ready,
    input  wire                logic [2:0] cfg_index,
    input  wire                logic [15:0] cfg_data
);
    import psc_pkg::*;

    psc_cfg_t   cfg_reg;
    psc_state_t state_reg;
    psc_state_t state_next;
    psc_in_t    in_item_reg;
    logic       in_valid_reg;
    psc_out_t   out_item_reg;
    psc_out_t   result;
    logic       out_valid_reg;
    logic       out_free;
    logic       advance;

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    psc_step u_step (
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INIT_WAIT:      cfg_reg.init_wait_sec      <= cfg_data;
                CFG_AC_TIMEOUT:     cfg_reg.ac_timeout_sec     <= cfg_data;
                CFG_CAMERA_BOOT:    cfg_reg.camera_boot_sec    <= cfg_data;
                CFG_PC_BOOT:        cfg_reg.pc_boot_sec        <= cfg_data;
                CFG_DC_GONE:        cfg_reg.dc_gone_sec        <= cfg_data;
                CFG_SHUTDOWN_ACK:   cfg_reg.shutdown_ack_sec   <= cfg_data;
                CFG_POWER_OFF_WAIT: cfg_reg.power_off_wait_sec <= cfg_data;
                CFG_AC_DETECT_MIN:  cfg_reg.ac_detect_min      <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                state_reg <= state_next;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_item;
        if (advance)
            out_item_reg <= result;
    end

endmodule

`default_nettype wire
